/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms, sampled on clk_i and muted during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that an expression never holds out of reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

/* src/crpe_pkg.sv */
// ----------------------------------------------------------------------------
// crpe_pkg
// Types and constants shared by the replacement policy engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crpe_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned LINE_IDX_W = 3;
  localparam int unsigned OUT_W      = 8;

  // Policy codes; the unused code behaves as CLOCK
  localparam logic [MODE_W-1:0] POL_LRU   = 2'd0;
  localparam logic [MODE_W-1:0] POL_LFU   = 2'd1;
  localparam logic [MODE_W-1:0] POL_CLOCK = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SWEEP,
    ST_WRITE
  } state_e;

  // Outcome of one directory scan
  typedef struct packed {
    logic hit;
    logic empty;
  } scan_flags_t;

endpackage

/* src/crpe_scan.sv */
// ----------------------------------------------------------------------------
// crpe_scan
// Shared compare unit: takes one directory line per cycle while cmp_valid_i
// is high and tracks the first hit, the first invalid line and the lowest-keyed line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crpe_scan #(
  parameter int unsigned LINES = 8,
  parameter int unsigned IW    = $clog2(LINES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        cmp_valid_i,
  input  logic [IW-1:0]               cmp_idx_i,
  input  logic                        line_valid_i,
  input  logic [crpe_pkg::ADDR_W-1:0] line_addr_i,
  input  logic [crpe_pkg::ADDR_W-1:0] target_i,
  input  logic [crpe_pkg::CNT_W-1:0]  key_i,
  input  logic [crpe_pkg::CNT_W-1:0]  count_i,
  output crpe_pkg::scan_flags_t       flags_o,
  output logic [IW-1:0]               hit_idx_o,
  output logic [IW-1:0]               empty_idx_o,
  output logic [IW-1:0]               min_idx_o,
  output logic [crpe_pkg::CNT_W-1:0]  hit_count_o
);
  import crpe_pkg::*;

  scan_flags_t      flags_q, flags_d;
  logic [IW-1:0]    hit_idx_q, hit_idx_d;
  logic [IW-1:0]    empty_idx_q, empty_idx_d;
  logic [IW-1:0]    min_idx_q, min_idx_d;
  logic [CNT_W-1:0] min_key_q, min_key_d;
  logic [CNT_W-1:0] hit_count_q, hit_count_d;
  logic             match;

  assign match = line_valid_i && (line_addr_i == target_i);

  // Fold the current line into the running results
  always_comb begin
    flags_d     = flags_q;
    hit_idx_d   = hit_idx_q;
    empty_idx_d = empty_idx_q;
    min_idx_d   = min_idx_q;
    min_key_d   = min_key_q;
    hit_count_d = hit_count_q;
    if (clear_i) begin
      flags_d = '0;
    end else if (cmp_valid_i) begin
      if (match && !flags_q.hit) begin
        flags_d.hit = 1'b1;
        hit_idx_d   = cmp_idx_i;
        hit_count_d = count_i;
      end
      if (!line_valid_i && !flags_q.empty) begin
        flags_d.empty = 1'b1;
        empty_idx_d   = cmp_idx_i;
      end
      // Strict compare keeps the lowest index on ties
      if (cmp_idx_i == '0 || key_i < min_key_q) begin
        min_key_d = key_i;
        min_idx_d = cmp_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    empty_idx_q <= empty_idx_d;
    min_idx_q   <= min_idx_d;
    min_key_q   <= min_key_d;
    hit_count_q <= hit_count_d;
  end

  assign flags_o     = flags_q;
  assign hit_idx_o   = hit_idx_q;
  assign empty_idx_o = empty_idx_q;
  assign min_idx_o   = min_idx_q;
  assign hit_count_o = hit_count_q;

endmodule

/* src/cache_replacement_policy_engine_core.sv */
// ----------------------------------------------------------------------------
// cache_replacement_policy_engine_core
// Fully associative cache directory with LRU, LFU or CLOCK replacement.
// ----------------------------------------------------------------------------
// s_axis carries one access address per word (tdata = access_address).
// m_axis returns one word per access: tdata bit 0 is hit, bits 3:1 the line
// that hit, was filled or was replaced. cfg writes the policy mode (LRU is
// 0, LFU is 1, CLOCK is 2 or 3); the user must make such writes only while
// no access is in flight, as the block does not enforce it. cfg_ready_o is
// always high. The directory lives in memories with registered reads and is
// walked one line per cycle through a single compare unit. An access is
// accepted in idle, scanned, decided and written back; a CLOCK eviction
// sweeps the hand in between, clearing set reference bits until it meets a
// clear one. The result word is registered at write-back. s_axis_tready_o is
// high only in idle: a new access waits until the last one is written back.
// Reset empties the directory, clears the access counter, the clock hand and
// the mode (LRU). A result word waits in the output register while the
// receiver stalls; the next access is taken and scanned meanwhile and holds
// before its write-back until that word is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cache_replacement_policy_engine_core #(
  parameter int unsigned LINES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Config channel: policy mode
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [crpe_pkg::MODE_W-1:0]   cfg_data_i,
  // Access in: [31:0] access_address
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [crpe_pkg::ADDR_W-1:0]   s_axis_tdata_i,
  // Result out: [0] hit, [3:1] line_index, [7:4] zero
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [crpe_pkg::OUT_W-1:0]    m_axis_tdata_o
);
  import crpe_pkg::*;

  localparam int unsigned    IW   = $clog2(LINES);
  localparam logic [IW-1:0]  LAST = IW'(LINES - 1);

  state_e            state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [MODE_W-1:0] cur_mode_q, cur_mode_d;
  logic [ADDR_W-1:0] target_q, target_d;
  logic [CNT_W-1:0]  counter_q, counter_d;
  logic [IW-1:0]     hand_q, hand_d;
  logic [LINES-1:0]  valid_q, valid_d;
  logic [LINES-1:0]  ref_q, ref_d;
  logic [LINES-1:0]  lu_wr_q, lu_wr_d;
  logic [LINES-1:0]  uc_wr_q, uc_wr_d;
  logic [IW-1:0]     rd_ptr_q, rd_ptr_d;
  logic              issue_q, issue_d;
  logic              cmp_valid_q, cmp_valid_d;
  logic [IW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [IW-1:0]     victim_q, victim_d;
  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  logic              in_fire;
  logic              scan_clear;
  logic              wr_go;

  // Directory memories and their registered read data
  logic [ADDR_W-1:0] addr_mem [LINES];
  logic [CNT_W-1:0]  lu_mem   [LINES];
  logic [CNT_W-1:0]  uc_mem   [LINES];
  logic [ADDR_W-1:0] addr_rd_q;
  logic [CNT_W-1:0]  lu_rd_q;
  logic [CNT_W-1:0]  uc_rd_q;
  logic              addr_we;
  logic              lu_we;
  logic              uc_we;
  logic [CNT_W-1:0]  lu_wdata;
  logic [CNT_W-1:0]  uc_wdata;

  // Compare unit feed and results
  logic [CNT_W-1:0]  lu_key;
  logic [CNT_W-1:0]  uc_key;
  logic [CNT_W-1:0]  scan_key;
  scan_flags_t       flags;
  logic [IW-1:0]     hit_idx;
  logic [IW-1:0]     empty_idx;
  logic [IW-1:0]     min_idx;
  logic [CNT_W-1:0]  hit_count;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign scan_clear      = in_fire;
  assign wr_go           = (state_q == ST_WRITE) && (!out_valid_q || m_axis_tready_i);

  // Lines never written read as zero
  assign lu_key   = lu_wr_q[cmp_idx_q] ? lu_rd_q : '0;
  assign uc_key   = uc_wr_q[cmp_idx_q] ? uc_rd_q : '0;
  assign scan_key = (cur_mode_q == POL_LRU) ? lu_key : uc_key;

  crpe_scan #(
    .LINES (LINES),
    .IW    (IW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_clear),
    .cmp_valid_i  (cmp_valid_q),
    .cmp_idx_i    (cmp_idx_q),
    .line_valid_i (valid_q[cmp_idx_q]),
    .line_addr_i  (addr_rd_q),
    .target_i     (target_q),
    .key_i        (scan_key),
    .count_i      (uc_key),
    .flags_o      (flags),
    .hit_idx_o    (hit_idx),
    .empty_idx_o  (empty_idx),
    .min_idx_o    (min_idx),
    .hit_count_o  (hit_count)
  );

  // Sequencer: scan, pick the line, sweep the hand, write back
  always_comb begin
    state_d     = state_q;
    cur_mode_d  = cur_mode_q;
    target_d    = target_q;
    counter_d   = counter_q;
    hand_d      = hand_q;
    valid_d     = valid_q;
    ref_d       = ref_q;
    lu_wr_d     = lu_wr_q;
    uc_wr_d     = uc_wr_q;
    rd_ptr_d    = rd_ptr_q;
    issue_d     = issue_q;
    cmp_valid_d = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    victim_d    = victim_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    addr_we     = 1'b0;
    lu_we       = 1'b0;
    uc_we       = 1'b0;
    lu_wdata    = counter_q;
    uc_wdata    = CNT_W'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          target_d   = s_axis_tdata_i;
          counter_d  = counter_q + CNT_W'(1);
          cur_mode_d = mode_q;
          rd_ptr_d   = '0;
          issue_d    = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue one read a cycle, compare it in the cycle after
        if (issue_q) begin
          cmp_valid_d = 1'b1;
          cmp_idx_d   = rd_ptr_q;
          if (rd_ptr_q == LAST) begin
            issue_d = 1'b0;
          end else begin
            rd_ptr_d = rd_ptr_q + IW'(1);
          end
        end
        if (cmp_valid_q && cmp_idx_q == LAST) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (flags.hit) begin
          victim_d = hit_idx;
          state_d  = ST_WRITE;
        end else if (flags.empty) begin
          victim_d = empty_idx;
          state_d  = ST_WRITE;
        end else if (cur_mode_q == POL_LRU || cur_mode_q == POL_LFU) begin
          victim_d = min_idx;
          state_d  = ST_WRITE;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // Clear set bits and advance; take the first clear line
        hand_d = (hand_q == LAST) ? '0 : hand_q + IW'(1);
        if (ref_q[hand_q]) begin
          ref_d[hand_q] = 1'b0;
        end else begin
          victim_d = hand_q;
          state_d  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (wr_go) begin
          if (!flags.hit) begin
            addr_we           = 1'b1;
            valid_d[victim_q] = 1'b1;
          end
          case (cur_mode_q)
            POL_LRU: begin
              lu_we             = 1'b1;
              lu_wr_d[victim_q] = 1'b1;
            end
            POL_LFU: begin
              uc_we             = 1'b1;
              uc_wr_d[victim_q] = 1'b1;
              if (flags.hit) begin
                uc_wdata = (hit_count == '1) ? hit_count : hit_count + CNT_W'(1);
              end
            end
            default: begin
              ref_d[victim_q] = 1'b1;
            end
          endcase
          out_valid_d = 1'b1;
          out_data_d  = {(OUT_W - LINE_IDX_W - 1)'(0), LINE_IDX_W'(victim_q), flags.hit};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= POL_LRU;
      cur_mode_q  <= POL_LRU;
      counter_q   <= '0;
      hand_q      <= '0;
      valid_q     <= '0;
      ref_q       <= '0;
      lu_wr_q     <= '0;
      uc_wr_q     <= '0;
      rd_ptr_q    <= '0;
      issue_q     <= 1'b0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      victim_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      cur_mode_q  <= cur_mode_d;
      counter_q   <= counter_d;
      hand_q      <= hand_d;
      valid_q     <= valid_d;
      ref_q       <= ref_d;
      lu_wr_q     <= lu_wr_d;
      uc_wr_q     <= uc_wr_d;
      rd_ptr_q    <= rd_ptr_d;
      issue_q     <= issue_d;
      cmp_valid_q <= cmp_valid_d;
      cmp_idx_q   <= cmp_idx_d;
      victim_q    <= victim_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    out_data_q <= out_data_d;
  end

  // Line address memory
  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[victim_q] <= target_q;
    end
    addr_rd_q <= addr_mem[rd_ptr_q];
  end

  // Last-use timestamp memory
  always_ff @(posedge clk_i) begin
    if (lu_we) begin
      lu_mem[victim_q] <= lu_wdata;
    end
    lu_rd_q <= lu_mem[rd_ptr_q];
  end

  // Use-count memory
  always_ff @(posedge clk_i) begin
    if (uc_we) begin
      uc_mem[victim_q] <= uc_wdata;
    end
    uc_rd_q <= uc_mem[rd_ptr_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `ASSERT_NEVER(a_hand_range, hand_q > LAST, "clock hand beyond last line")
  `ASSERT_CLK(a_sweep_full, state_q == ST_SWEEP |-> &valid_q, "sweep with a free line")
  `ASSERT_CLK(a_out_from_write, $rose(m_axis_tvalid_o) |-> $past(state_q == ST_WRITE),
              "result raised outside write-back")
  `ASSERT_CLK(a_fill_valid, wr_go && !flags.hit |=> valid_q[$past(victim_q)],
              "filled line not marked valid")

endmodule
